// ----- hdl/ils_pkg.sv -----
package ils_pkg;

  typedef enum logic [2:0] {
    MODE_APPEND  = 3'd0,
    MODE_READ    = 3'd1,
    MODE_POP     = 3'd2,
    MODE_REMOVE  = 3'd3,
    MODE_INSERT  = 3'd4,
    MODE_REPLACE = 3'd5
  } mode_e;

  // Broadcast action for the cell chain.
  typedef enum logic [1:0] {
    ACT_HOLD  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_DOWN  = 2'd2,
    ACT_UP    = 2'd3
  } act_e;

  localparam int unsigned PosBits    = 4;
  localparam int unsigned PosEntries = 1 << PosBits;
  localparam int unsigned OutBits    = 32;
  localparam int unsigned LenBits    = 5;

endpackage

// ----- hdl/ils_cell.sv -----
module ils_cell #(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned CW        = 5
) (
  input  logic                 clk_i,
  input  ils_pkg::act_e        act_i,
  input  logic [CW-1:0]        lo_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  output logic [WORD_BITS-1:0] cell_o
);
  import ils_pkg::*;

  localparam logic [CW-1:0] IdxC = CW'(INDEX);

  logic [WORD_BITS-1:0] cell_d, cell_q;

  always_comb begin
    cell_d = cell_q;
    case (act_i)
      ACT_WRITE: begin
        if (IdxC == lo_i) cell_d = wdata_i;
      end
      ACT_DOWN: begin
        if (IdxC >= lo_i) cell_d = right_i;
      end
      ACT_UP: begin
        if (IdxC > lo_i) begin
          cell_d = left_i;
        end else if (IdxC == lo_i) begin
          cell_d = wdata_i;
        end
      end
      default: cell_d = cell_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ----- hdl/ils_ctrl.sv -----
module ils_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CW       = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        mode_i,
  input  logic [ils_pkg::PosBits-1:0]       position_i,
  input  logic [ils_pkg::OutBits-1:0]       rd_word_i,
  input  logic [ils_pkg::OutBits-1:0]       head_word_i,
  output ils_pkg::act_e                     act_o,
  output logic [CW-1:0]                     lo_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic [ils_pkg::OutBits-1:0]       word_out_o,
  output logic [ils_pkg::LenBits-1:0]       length_o,
  output logic                              empty_res_o,
  output logic                              full_res_o
);
  import ils_pkg::*;

  localparam int unsigned XW = (CW > PosBits) ? CW : PosBits;
  localparam int unsigned LW = (CW > LenBits) ? CW : LenBits;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  logic [CW-1:0]      count_d, count_q;
  logic               out_valid_d, out_valid_q;
  logic               ok_q;
  logic [OutBits-1:0] word_q;
  logic [LenBits-1:0] len_q;
  logic               empty_q, full_q;

  logic               fire, in_range, not_full, ok;
  logic [OutBits-1:0] word;
  logic [CW-1:0]      count_nx;
  act_e               act;
  logic [CW-1:0]      lo;
  logic [LW-1:0]      len_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign fire       = in_valid_i && !in_stall_o;
  assign in_range   = XW'(position_i) < XW'(count_q);
  assign not_full   = count_q != CapC;

  always_comb begin
    ok       = 1'b0;
    word     = '0;
    count_nx = count_q;
    act      = ACT_HOLD;
    lo       = count_q;
    case (mode_e'(mode_i))
      MODE_APPEND: begin
        if (not_full) begin
          ok       = 1'b1;
          act      = ACT_WRITE;
          count_nx = count_q + 1'b1;
        end
      end
      MODE_READ: begin
        if (in_range) begin
          ok   = 1'b1;
          word = rd_word_i;
        end
      end
      MODE_POP: begin
        if (count_q != '0) begin
          ok       = 1'b1;
          word     = head_word_i;
          act      = ACT_DOWN;
          lo       = '0;
          count_nx = count_q - 1'b1;
        end else begin
          word = '1;
        end
      end
      MODE_REMOVE: begin
        if (in_range) begin
          ok       = 1'b1;
          act      = ACT_DOWN;
          lo       = CW'(position_i);
          count_nx = count_q - 1'b1;
        end
      end
      MODE_INSERT: begin
        if (in_range && not_full) begin
          ok       = 1'b1;
          act      = ACT_UP;
          lo       = CW'(position_i);
          count_nx = count_q + 1'b1;
        end
      end
      MODE_REPLACE: begin
        if (in_range) begin
          ok  = 1'b1;
          act = ACT_WRITE;
          lo  = CW'(position_i);
        end
      end
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    act_o       = fire ? act : ACT_HOLD;
    lo_o        = lo;
    count_d     = fire ? count_nx : count_q;
    len_ext     = LW'(count_nx);
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ok_q    <= ok;
      word_q  <= word;
      len_q   <= len_ext[LenBits-1:0];
      empty_q <= count_nx == '0;
      full_q  <= count_nx == CapC;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign word_out_o  = word_q;
  assign length_o    = len_q;
  assign empty_res_o = empty_q;
  assign full_res_o  = full_q;

endmodule

// ----- hdl/indexed_list_store_top.sv -----
// An ordered list of up to CAPACITY words held in a row of cells, one word per cell.
// Each beat carries one command (append, read, pop front, remove, insert or replace) and
// returns one result beat with an ok flag, the word read, the new length and the empty and
// full flags. The affected cells shift or are written together in the cycle a command is accepted,
// and the result appears in the output register on the next cycle.
// A new beat is accepted every cycle as long as the result side does not stall.
module indexed_list_store_top #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         mode_i,
  input  logic [ils_pkg::PosBits-1:0]        position_i,
  input  logic signed [ils_pkg::OutBits-1:0] word_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               ok_o,
  output logic signed [ils_pkg::OutBits-1:0] word_out_o,
  output logic [ils_pkg::LenBits-1:0]        length_o,
  output logic                               empty_res_o,
  output logic                               full_res_o
);
  import ils_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [WORD_BITS-1:0] cell_q [CAPACITY];
  logic [WORD_BITS-1:0] rd_tab [PosEntries];
  logic [WORD_BITS-1:0] wdata, rd_word;
  logic [OutBits-1:0]   rd_word32, head_word32, word_out;
  act_e                 act;
  logic [CW-1:0]        lo;

  assign rd_word = rd_tab[position_i];

  generate
    if (WORD_BITS >= OutBits) begin : g_wide
      assign wdata       = WORD_BITS'(word_in_i);
      assign rd_word32   = rd_word[OutBits-1:0];
      assign head_word32 = cell_q[0][OutBits-1:0];
    end else begin : g_narrow
      assign wdata       = word_in_i[WORD_BITS-1:0];
      assign rd_word32   = OutBits'(rd_word);
      assign head_word32 = OutBits'(cell_q[0]);
    end

    for (genvar k = 0; k < PosEntries; k++) begin : g_rd
      if (k < CAPACITY) begin : g_cell
        assign rd_tab[k] = cell_q[k];
      end else begin : g_none
        assign rd_tab[k] = '0;
      end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
      logic [WORD_BITS-1:0] left, right;
      if (i == 0) begin : g_first
        assign left = wdata;
      end else begin : g_left
        assign left = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right = cell_q[i];
      end else begin : g_right
        assign right = cell_q[i+1];
      end
      ils_cell #(
        .INDEX    (i),
        .WORD_BITS(WORD_BITS),
        .CW       (CW)
      ) u_cell (
        .clk_i  (clk_i),
        .act_i  (act),
        .lo_i   (lo),
        .wdata_i(wdata),
        .left_i (left),
        .right_i(right),
        .cell_o (cell_q[i])
      );
    end
  endgenerate

  ils_ctrl #(
    .CAPACITY(CAPACITY),
    .CW      (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .position_i (position_i),
    .rd_word_i  (rd_word32),
    .head_word_i(head_word32),
    .act_o      (act),
    .lo_o       (lo),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ok_o       (ok_o),
    .word_out_o (word_out),
    .length_o   (length_o),
    .empty_res_o(empty_res_o),
    .full_res_o (full_res_o)
  );

  assign word_out_o = word_out;

endmodule
